>>> sv/allocation_tracking_table_unit_assert.svh
// Assertion macros for the allocation tracking table.
// Used by the port checker; needs clk and arst_n in scope.
`ifndef ALLOCATION_TRACKING_TABLE_UNIT_ASSERT_SVH
`define ALLOCATION_TRACKING_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define ATT_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("allocation tracking table: assertion failed");

// next-cycle implication
`define ATT_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("allocation tracking table: assertion failed");

`endif

>>> sv/att_pkg.sv
// Package for the allocation tracking table: record layouts, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

	localparam int NUM_POOLS_DEF   = 2;
	localparam int TABLE_DEPTH_DEF = 512;
	localparam int MISS_DEPTH_DEF  = 256;

	// event kinds
	localparam logic [3:0] ACT_REALLOC   = 4'd7;
	localparam logic [3:0] ACT_ALLOC_A   = 4'd8;
	localparam logic [3:0] ACT_ALLOC_Z   = 4'd9;
	localparam logic [3:0] ACT_FREE      = 4'd10;
	localparam logic [3:0] ACT_FREE_R    = 4'd11;
	localparam logic [3:0] ACT_SAVE      = 4'd12;
	localparam logic [3:0] ACT_SET_FREE  = 4'd13;
	localparam logic [3:0] ACT_GET_FREE  = 4'd14;
	localparam logic [3:0] ACT_TOUCH     = 4'd15;

	// result status
	localparam logic [1:0] STS_HIT    = 2'd0;
	localparam logic [1:0] STS_LOGGED = 2'd1;
	localparam logic [1:0] STS_LOST   = 2'd2;
	localparam logic [1:0] STS_IGNORE = 2'd3;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_RELEASE,
		OP_SAVE,
		OP_SETH,
		OP_PEEK,
		OP_REWRITE,
		OP_MOVE
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  kind;
		logic [63:0] address;
		logic [63:0] handler;
		logic [63:0] caller;
		logic [63:0] time_ms;
		logic [31:0] elements;
		logic [47:0] bytes;
		logic [31:0] align;
		logic [31:0] refs;
	} entry_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] address;
		logic [63:0] other;
		logic [63:0] caller;
		logic [63:0] time_ms;
		logic [31:0] elements;
		logic [47:0] bytes;
		logic [31:0] align;
	} miss_rec_t;

	typedef struct packed {
		logic       en;
		logic [1:0] pool;
	} miss_req_t;

endpackage

`default_nettype wire

>>> sv/att_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module att_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                 wr_data,
	input  wire logic                             rd_en,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> sv/att_miss_log.sv
// Per-pool miss log: fill counters and the record memory.
// Depends on att_pkg and att_ram.
`timescale 1ns / 1ps
`default_nettype none

module att_miss_log #(
	parameter int NUM_POOLS  = att_pkg::NUM_POOLS_DEF,
	parameter int MISS_DEPTH = att_pkg::MISS_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire att_pkg::miss_req_t             req,
	input  wire att_pkg::miss_rec_t             rec,
	output logic [$clog2(MISS_DEPTH+1)-1:0]     fill,
	output logic                                full
);

	localparam int FW  = $clog2(MISS_DEPTH + 1);
	localparam int PW  = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int ENT = NUM_POOLS * MISS_DEPTH;
	localparam int MAW = (ENT > 1) ? $clog2(ENT) : 1;

	logic [FW-1:0]  fill_q [NUM_POOLS];
	logic [PW-1:0]  pidx;
	logic           wr_en;
	logic [MAW-1:0] wr_addr;

	assign pidx  = req.pool[PW-1:0];
	assign fill  = fill_q[pidx];
	assign full  = (fill == FW'(MISS_DEPTH));
	assign wr_en = req.en && !full;
	// record slot: pool base plus fill
	assign wr_addr = MAW'(32'(pidx) * MISS_DEPTH + 32'(fill));

	// fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POOLS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (wr_en) begin
			fill_q[pidx] <= fill + FW'(1);
		end
	end

	att_ram #(
		.WIDTH ($bits(att_pkg::miss_rec_t)),
		.DEPTH (ENT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rec),
		.rd_en   (1'b0),
		.rd_addr ('0),
		.rd_data ()
	);

endmodule

`default_nettype wire

>>> sv/allocation_tracking_table_unit.sv
// Flow: an accepted event scans its pool's table, then modifies it and reports; a moving realloc
// scans twice; a pool out of range skips the scan and reports at once.
// One event at a time, the next accepted on the edge of the result beat;
// the table scan goes through the single read port of the entry memory.
// Reset: a clearing pass over all NUM_POOLS*TABLE_DEPTH entries, busy high meanwhile.
// Results show for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module allocation_tracking_table_unit #(
	parameter int NUM_POOLS   = att_pkg::NUM_POOLS_DEF,
	parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
	parameter int MISS_DEPTH  = att_pkg::MISS_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [3:0]                    action,
	input  wire logic [1:0]                    pool_id,
	input  wire logic [63:0]                   address,
	input  wire logic [63:0]                   other_address,
	input  wire logic [31:0]                   block_count,
	input  wire logic [47:0]                   byte_size,
	input  wire logic [31:0]                   alignment,
	input  wire logic [63:0]                   caller_address,
	input  wire logic [63:0]                   time_ms,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [31:0]                        use_count,
	output logic [$clog2(MISS_DEPTH+1)-1:0]    log_count
);

	localparam int ENT = NUM_POOLS * TABLE_DEPTH;
	localparam int AW  = $clog2(ENT);
	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int LW  = $clog2(MISS_DEPTH + 1);

	att_pkg::state_t state_q, state_d;

	// captured event
	logic [3:0]  action_q;
	logic [1:0]  pool_q;
	logic [63:0] addr_q, other_q, caller_q, time_q;
	logic [31:0] elem_q, align_q;
	logic [47:0] bytes_q;
	logic [AW-1:0] base_q;
	att_pkg::op_t  op_q;
	logic        ign_q, phase_q, a_ok_q, hit_q;
	logic [31:0] cnt_q;

	// scan state
	logic [CW-1:0] idx_q;
	logic          rd_pend_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q, free_q;
	logic [IW-1:0] slot_q, free_idx_q;
	att_pkg::entry_t word_q;
	logic [AW-1:0] clr_q;

	// memory port
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	att_pkg::entry_t wr_data, rd_data, rec_new, w;
	logic [63:0]   key;
	logic          scan_last, ok;
	logic [31:0]   cnt;
	att_pkg::op_t  eff_op, op_dec;

	// miss log
	att_pkg::miss_req_t miss_req;
	att_pkg::miss_rec_t miss_rec;
	logic [LW-1:0]      fill;
	logic               full;

	assign busy = (state_q != att_pkg::ST_IDLE);
	assign key  = (op_q == att_pkg::OP_MOVE && !phase_q) ? other_q : addr_q;
	assign rd_en   = (state_q == att_pkg::ST_SCAN) && (idx_q < CW'(TABLE_DEPTH));
	assign rd_addr = base_q + AW'(idx_q[IW-1:0]);
	assign scan_last = rd_pend_s1 && (idx_s1 == IW'(TABLE_DEPTH - 1));
	assign eff_op = (op_q == att_pkg::OP_MOVE) ?
		(phase_q ? att_pkg::OP_INSERT : att_pkg::OP_RELEASE) : op_q;

	always_comb begin
		rec_new          = '0;
		rec_new.valid    = 1'b1;
		rec_new.kind     = action_q;
		rec_new.address  = addr_q;
		rec_new.caller   = caller_q;
		rec_new.time_ms  = time_q;
		rec_new.elements = elem_q;
		rec_new.bytes    = bytes_q;
		rec_new.align    = align_q;
		rec_new.refs     = 32'd1;
	end

	// event decode
	always_comb begin
		unique case (action)
			att_pkg::ACT_FREE, att_pkg::ACT_FREE_R: op_dec = att_pkg::OP_RELEASE;
			att_pkg::ACT_SAVE:                      op_dec = att_pkg::OP_SAVE;
			att_pkg::ACT_SET_FREE:                  op_dec = att_pkg::OP_SETH;
			att_pkg::ACT_GET_FREE, att_pkg::ACT_TOUCH: op_dec = att_pkg::OP_PEEK;
			att_pkg::ACT_REALLOC: begin
				if (other_address == address)   op_dec = att_pkg::OP_REWRITE;
				else if (other_address != '0)   op_dec = att_pkg::OP_MOVE;
				else                            op_dec = att_pkg::OP_INSERT;
			end
			default:                                op_dec = att_pkg::OP_INSERT;
		endcase
	end

	// next state, table write-back and outcome of the modify step
	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = base_q + AW'(slot_q);
		wr_data = word_q;
		w       = word_q;
		ok      = 1'b0;
		cnt     = '0;
		unique case (state_q)
			att_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == AW'(ENT - 1)) state_d = att_pkg::ST_IDLE;
			end
			att_pkg::ST_IDLE: begin
				if (start) begin
					if (32'(pool_id) >= 32'(NUM_POOLS)) state_d = att_pkg::ST_FIN;
					else                                state_d = att_pkg::ST_SCAN;
				end
			end
			att_pkg::ST_SCAN: begin
				if (scan_last) state_d = att_pkg::ST_ACT;
			end
			att_pkg::ST_ACT: begin
				unique case (eff_op)
					att_pkg::OP_INSERT: begin
						if (!found_q && free_q) begin
							wr_en   = 1'b1;
							wr_addr = base_q + AW'(free_idx_q);
							wr_data = rec_new;
							ok      = 1'b1;
							cnt     = 32'd1;
						end
					end
					att_pkg::OP_RELEASE: begin
						w.refs = word_q.refs - 32'd1;
						if (w.refs == '0) w.valid = 1'b0;
						wr_data = w;
						wr_en   = found_q;
						ok      = found_q;
						cnt     = w.refs;
					end
					att_pkg::OP_SAVE: begin
						if (word_q.refs != 32'hFFFF_FFFF) w.refs = word_q.refs + 32'd1;
						wr_data = w;
						wr_en   = found_q;
						ok      = found_q;
						cnt     = w.refs;
					end
					att_pkg::OP_SETH: begin
						w.handler = other_q;
						wr_data   = w;
						wr_en     = found_q;
						ok        = found_q;
						cnt       = word_q.refs;
					end
					att_pkg::OP_PEEK: begin
						ok  = found_q;
						cnt = word_q.refs;
					end
					att_pkg::OP_REWRITE: begin
						wr_data = rec_new;
						wr_en   = found_q;
						ok      = found_q;
						cnt     = 32'd1;
					end
					default: begin
					end
				endcase
				if (op_q == att_pkg::OP_MOVE && !phase_q) state_d = att_pkg::ST_SCAN;
				else                                      state_d = att_pkg::ST_FIN;
			end
			att_pkg::ST_FIN: begin
				state_d = att_pkg::ST_IDLE;
			end
			default: state_d = att_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= att_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			phase_q    <= 1'b0;
			ign_q      <= 1'b0;
			done       <= 1'b0;
		end else begin
			done <= (state_q == att_pkg::ST_FIN);
			if (state_q == att_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == att_pkg::ST_IDLE && start) begin
				ign_q   <= (32'(pool_id) >= 32'(NUM_POOLS));
				phase_q <= 1'b0;
			end
			if (state_d == att_pkg::ST_SCAN && state_q != att_pkg::ST_SCAN) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (state_q == att_pkg::ST_SCAN) begin
				if (rd_en) idx_q <= idx_q + CW'(1);
				// compare the entry read last cycle
				if (rd_pend_s1) begin
					if (rd_data.valid && rd_data.address == key && !found_q) found_q <= 1'b1;
					if (!rd_data.valid && !free_q) free_q <= 1'b1;
				end
			end
			if (state_q == att_pkg::ST_ACT) phase_q <= 1'b1;
			rd_pend_s1 <= rd_en;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == att_pkg::ST_IDLE && start) begin
			action_q <= action;
			pool_q   <= pool_id;
			addr_q   <= address;
			other_q  <= other_address;
			elem_q   <= block_count;
			bytes_q  <= byte_size;
			align_q  <= alignment;
			caller_q <= caller_address;
			time_q   <= time_ms;
			op_q     <= op_dec;
			base_q   <= AW'(32'(pool_id) * TABLE_DEPTH);
		end
		if (rd_en) idx_s1 <= idx_q[IW-1:0];
		if (state_q == att_pkg::ST_SCAN && rd_pend_s1) begin
			if (rd_data.valid && rd_data.address == key && !found_q) begin
				slot_q <= idx_s1;
				word_q <= rd_data;
			end
			if (!rd_data.valid && !free_q) free_idx_q <= idx_s1;
		end
		if (state_q == att_pkg::ST_ACT) begin
			if (op_q == att_pkg::OP_MOVE && !phase_q) begin
				a_ok_q <= ok;
			end else begin
				hit_q <= ok && (op_q != att_pkg::OP_MOVE || a_ok_q);
				cnt_q <= cnt;
			end
		end
		// result
		if (state_q == att_pkg::ST_FIN) begin
			if (ign_q) begin
				status    <= att_pkg::STS_IGNORE;
				use_count <= '0;
				log_count <= '0;
			end else if (hit_q) begin
				status    <= att_pkg::STS_HIT;
				use_count <= cnt_q;
				log_count <= fill;
			end else if (!full) begin
				status    <= att_pkg::STS_LOGGED;
				use_count <= '0;
				log_count <= fill + LW'(1);
			end else begin
				status    <= att_pkg::STS_LOST;
				use_count <= '0;
				log_count <= fill;
			end
		end
	end

	att_ram #(
		.WIDTH ($bits(att_pkg::entry_t)),
		.DEPTH (ENT)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// miss record from the captured event
	assign miss_req.en   = (state_q == att_pkg::ST_FIN) && !ign_q && !hit_q;
	assign miss_req.pool = pool_q;
	assign miss_rec = '{kind: action_q, address: addr_q, other: other_q,
		caller: caller_q, time_ms: time_q, elements: elem_q,
		bytes: bytes_q, align: align_q};

	att_miss_log #(
		.NUM_POOLS  (NUM_POOLS),
		.MISS_DEPTH (MISS_DEPTH)
	) u_miss (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (miss_req),
		.rec    (miss_rec),
		.fill   (fill),
		.full   (full)
	);

endmodule

`default_nettype wire

>>> sv/att_checker.sv
// Port checker for the allocation tracking table, bound to the top level.
// Depends on att_pkg and allocation_tracking_table_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "allocation_tracking_table_unit_assert.svh"

module att_checker #(
	parameter int LW = 9
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire logic [1:0]    status,
	input wire logic [31:0]   use_count,
	input wire logic [LW-1:0] log_count
);

	// an accepted event raises busy
	`ATT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// a result beat follows a busy cycle
	`ATT_ASSERT_IMP(a_done_after_busy, done, $past(busy))
	// ignored pool reports nothing
	`ATT_ASSERT_IMP(a_ignore_zero, done && status == att_pkg::STS_IGNORE, use_count == '0 && log_count == '0)
	// any miss reports zero references
	`ATT_ASSERT_IMP(a_miss_zero, done && status != att_pkg::STS_HIT, use_count == '0)

endmodule

bind allocation_tracking_table_unit att_checker #(
	.LW ($clog2(MISS_DEPTH + 1))
) u_att_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.use_count (use_count),
	.log_count (log_count)
);

`default_nettype wire
